FILE: rtl/core/pgce_pkg.sv
// Shared types, codes and constants of the per-peer credit grant engine.
package pgce_pkg;

	localparam int DEF_NUM_PEERS = 16;

	localparam int PEER_W   = 4;
	localparam int AMT_W    = 40;
	localparam int GRANT_W  = 26;
	localparam int CHUNK_W  = 21;
	localparam int BURST_W  = 6;
	localparam int IPOOL_W  = 32;
	localparam int CNT_W    = 64;
	localparam int LIMIT_W  = CHUNK_W + BURST_W;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 1;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(30000);
	localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(10);
	localparam logic [IPOOL_W-1:0] IPOOL_RESET = IPOOL_W'(104857600);
	localparam logic [CNT_W-1:0]   POOL_RESET  = CNT_W'(104857600);
	localparam logic [GRANT_W-1:0] GRANT_MAX   = '1;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_CHUNK_BYTES  = 2'd0;
	localparam logic [1:0] REG_BURST_CHUNKS = 2'd1;
	localparam logic [1:0] REG_INITIAL_POOL = 2'd2;

	localparam logic KIND_GRANT = 1'b0;
	localparam logic KIND_ACK   = 1'b1;

	typedef enum logic [1:0] {
		OP_REQUEST   = 2'd0,
		OP_UPDATE    = 2'd1,
		OP_ABORT     = 2'd2,
		OP_TERMINATE = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_APPLY,
		ST_CHECK,
		ST_LIMIT,
		ST_WRITE
	} state_e;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_bytes;
		logic [BURST_W-1:0] burst_chunks;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] requested;
		logic [CNT_W-1:0] credited;
		logic [CNT_W-1:0] received;
	} entry_t;

	typedef struct packed {
		logic               kind;
		logic [PEER_W-1:0]  peer;
		logic [GRANT_W-1:0] bytes;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

FILE: rtl/core/per_peer_credit_grant_engine_unit.sv
// Top level of the per-peer credit grant engine: sequencer, datapath and pool.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the peer table with
// s_tready low. Configuration writes are taken throughout. An accepted input passes the
// apply, check and limit states; its results are pushed to the result queue in the write
// state, which waits while the queue lacks room for two. A new input is taken only when
// idle, after the peer table read-modify-write (read, apply, check, limit, write back).
module per_peer_credit_grant_engine_unit #(
	parameter int NUM_PEERS = pgce_pkg::DEF_NUM_PEERS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: [3:0] peer_index, [43:4] byte_amount, [47:44] zero
	input  logic [pgce_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: [1:0] operation
	input  logic [pgce_pkg::S_TUSER_W-1:0] s_tuser,
	// Result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: [3:0] grant_peer, [29:4] grant_bytes, [31:30] zero
	output logic [pgce_pkg::M_TDATA_W-1:0] m_tdata,
	// m_tuser: [0] result_kind
	output logic [pgce_pkg::M_TUSER_W-1:0] m_tuser,
	// m_tlast: last_result
	output logic                           m_tlast,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pgce_pkg::APB_AW-1:0]    paddr,
	input  logic [pgce_pkg::APB_DW-1:0]    pwdata,
	output logic [pgce_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);
	import pgce_pkg::*;

	localparam int AW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PEERS - 1);
	localparam logic [10:0]   NUM_PEERS_L = 11'(NUM_PEERS);

	cfg_t    cfg;
	state_e  state_q, state_d;
	push_t   push;
	result_t head;
	logic    room2;

	// Peer table port signals
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, rd_entry;

	// Clearing pass
	logic [AW-1:0] clr_cnt_q;

	// Transaction held through the pipeline
	op_e                op_s1;
	logic [PEER_W-1:0]  peer_s1;
	logic [AMT_W-1:0]   amt_s1;
	logic               valid_s1;
	logic [CNT_W-1:0]   req_s2, cred_s2, recv_s2;
	logic               pool_ok_s3, out_ok_s3;
	logic [CNT_W-1:0]   rem_s3;
	logic [LIMIT_W-1:0] lim_s3;
	logic [GRANT_W-1:0] grant_s4;
	logic               grant_ok_s4;
	logic [CNT_W-1:0]   pool_q;

	// Stage logic
	logic               accept, wr_fire;
	logic               in_valid;
	logic [CNT_W:0]     pool_sum;
	logic [CNT_W-1:0]   outstanding, min_v;
	logic [LIMIT_W-1:0] limit_v;
	logic [GRANT_W-1:0] grant_v;
	logic               is_ack;

	pgce_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pgce_peer_mem #(
		.DEPTH (NUM_PEERS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_entry)
	);

	pgce_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room2    (room2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	assign m_tdata = {2'b00, head.bytes, head.peer};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_cnt_q == LAST_ADDR) state_d = ST_IDLE;
			ST_IDLE:  if (s_tvalid) state_d = ST_APPLY;
			ST_APPLY: state_d = ST_CHECK;
			ST_CHECK: state_d = ST_LIMIT;
			ST_LIMIT: state_d = ST_WRITE;
			ST_WRITE: if (room2) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		wr_fire  = 1'b0;
		mem_we   = 1'b0;
		case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE:  s_tready = 1'b1;
			ST_WRITE: begin
				wr_fire = room2;
				mem_we  = room2 & valid_s1;
			end
			default: ;
		endcase
	end

	assign accept   = s_tvalid & s_tready;
	assign in_valid = ({7'd0, s_tdata[PEER_W-1:0]} < NUM_PEERS_L);

	// Read the entry at accept so it is there in the apply cycle; the previous
	// transaction has already written back, so no forwarding is needed.
	assign mem_re    = accept & in_valid;
	assign mem_raddr = AW'(s_tdata[PEER_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_e'(s_tuser);
			peer_s1  <= s_tdata[PEER_W-1:0];
			amt_s1   <= s_tdata[PEER_W +: AMT_W];
			valid_s1 <= in_valid;
		end
	end

	// Apply: fold the operation into the entry
	always_ff @(posedge clk) begin
		if (state_q == ST_APPLY) begin
			if (op_s1 == OP_ABORT) begin
				req_s2  <= '0;
				cred_s2 <= '0;
				recv_s2 <= '0;
			end else begin
				req_s2  <= (op_s1 == OP_REQUEST) ?
					rd_entry.requested + CNT_W'(amt_s1) : rd_entry.requested;
				cred_s2 <= rd_entry.credited;
				recv_s2 <= (op_s1 == OP_UPDATE) ?
					rd_entry.received + CNT_W'(amt_s1) : rd_entry.received;
			end
		end
	end

	// Check: pool, outstanding credit and unrequested remainder
	assign outstanding = cred_s2 - recv_s2;
	assign limit_v     = LIMIT_W'(cfg.burst_chunks) * LIMIT_W'(cfg.chunk_bytes);

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			pool_ok_s3 <= (pool_q >= CNT_W'(cfg.chunk_bytes));
			out_ok_s3  <= (outstanding <= CNT_W'({cfg.chunk_bytes, 1'b0}));
			rem_s3     <= req_s2 - cred_s2;
			lim_s3     <= limit_v;
		end
	end

	// Limit: smaller of remainder and burst limit, clipped to the field
	assign min_v   = (rem_s3 < CNT_W'(lim_s3)) ? rem_s3 : CNT_W'(lim_s3);
	assign grant_v = (|min_v[CNT_W-1:GRANT_W]) ? GRANT_MAX : min_v[GRANT_W-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_LIMIT) begin
			grant_s4    <= grant_v;
			grant_ok_s4 <= valid_s1 & (op_s1 != OP_ABORT) & pool_ok_s3 & out_ok_s3 &
				(grant_v != '0);
		end
	end

	// Pool: saturating add on update, saturating take on grant
	assign pool_sum = {1'b0, pool_q} + (CNT_W + 1)'(amt_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_RESET;
		end else if (state_q == ST_APPLY && valid_s1 && op_s1 == OP_UPDATE) begin
			pool_q <= pool_sum[CNT_W] ? '1 : pool_sum[CNT_W-1:0];
		end else if (wr_fire && grant_ok_s4) begin
			pool_q <= (pool_q > CNT_W'(grant_s4)) ? pool_q - CNT_W'(grant_s4) : '0;
		end
	end

	// Write back; the clearing pass owns the port until it ends
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_waddr          = AW'(peer_s1);
			mem_wdata.requested = req_s2;
			mem_wdata.credited  = cred_s2 + (grant_ok_s4 ? CNT_W'(grant_s4) : '0);
			mem_wdata.received  = recv_s2;
		end
	end

	// Results: acknowledge first on terminate, then the grant if any
	assign is_ack = (op_s1 == OP_TERMINATE);

	always_comb begin
		push.count  = 2'd0;
		push.first  = '{kind: KIND_GRANT, peer: peer_s1, bytes: grant_s4, last: 1'b1};
		push.second = '{kind: KIND_GRANT, peer: peer_s1, bytes: grant_s4, last: 1'b1};
		if (is_ack) begin
			push.first = '{kind: KIND_ACK, peer: peer_s1, bytes: '0, last: !grant_ok_s4};
		end
		if (wr_fire) begin
			push.count = {1'b0, is_ack} + {1'b0, grant_ok_s4};
		end
	end

endmodule

FILE: rtl/core/pgce_cfg_regs.sv
// APB configuration registers of the credit grant engine.
module pgce_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pgce_pkg::APB_AW-1:0]  paddr,
	input  logic [pgce_pkg::APB_DW-1:0]  pwdata,
	output logic [pgce_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	output pgce_pkg::cfg_t               cfg
);
	import pgce_pkg::*;

	logic [CHUNK_W-1:0] chunk_q;
	logic [BURST_W-1:0] burst_q;
	logic [IPOOL_W-1:0] ipool_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= CHUNK_RESET;
			burst_q <= BURST_RESET;
			ipool_q <= IPOOL_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_CHUNK_BYTES:  chunk_q <= pwdata[CHUNK_W-1:0];
				REG_BURST_CHUNKS: burst_q <= pwdata[BURST_W-1:0];
				REG_INITIAL_POOL: ipool_q <= pwdata[IPOOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CHUNK_BYTES:  prdata = APB_DW'(chunk_q);
			REG_BURST_CHUNKS: prdata = APB_DW'(burst_q);
			REG_INITIAL_POOL: prdata = APB_DW'(ipool_q);
			default:          prdata = '0;
		endcase
	end

	assign cfg.chunk_bytes  = chunk_q;
	assign cfg.burst_chunks = burst_q;

endmodule

FILE: rtl/core/pgce_peer_mem.sv
// Peer table memory: one write port, one registered read port.
module pgce_peer_mem #(
	parameter int DEPTH = pgce_pkg::DEF_NUM_PEERS,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  pgce_pkg::entry_t wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output pgce_pkg::entry_t rdata
);
	import pgce_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/pgce_result_fifo.sv
// Four-entry result queue that takes up to two results per push.
module pgce_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  pgce_pkg::push_t   push,
	output logic              room2,
	output logic              m_tvalid,
	input  logic              m_tready,
	output pgce_pkg::result_t head
);
	import pgce_pkg::*;

	result_t    slot_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign m_tvalid = (count_q != 3'd0);
	assign pop      = m_tvalid & m_tready;
	assign room2    = (count_q <= 3'd2);
	assign head     = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[wptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			slot_q[wptr_q + 2'd1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + push.count;
			rptr_q  <= rptr_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push.count} - {2'b0, pop};
		end
	end

endmodule

FILE: verif/tb_per_peer_credit_grant_engine_unit.sv
// Self-checking testbench for the per-peer credit grant engine: directed script, then random phases.
module tb_per_peer_credit_grant_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import pgce_pkg::*;

	// Register index with no register behind it; writes there must change nothing.
	localparam logic [1:0] REG_SPARE = 2'd3;

	// Cycles to let pass before a register write once nothing is expected: covers an item
	// still in flight that makes no result, through to its write back.
	localparam int DRAIN_CYCLES = 16;
	// Length of the long receiver hold-off in the back-pressure phase.
	localparam int HOLD_CYCLES  = 600;
	// Watchdog, many times the slowest correct run (about 1800 items, two results each,
	// worst gaps and stalls, the clearing pass and the hold-off).
	localparam int LIMIT_CYCLES = 400000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	// s_tdata: [3:0] peer_index, [43:4] byte_amount, [47:44] zero
	logic [S_TDATA_W-1:0]  s_tdata;
	// s_tuser: [1:0] operation
	logic [S_TUSER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// m_tdata: [3:0] grant_peer, [29:4] grant_bytes, [31:30] zero
	logic [M_TDATA_W-1:0]  m_tdata;
	// m_tuser: [0] result_kind
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  m_tlast;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_AW-1:0]     paddr;
	logic [APB_DW-1:0]     pwdata;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	per_peer_credit_grant_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Shadow of the configuration registers.
	logic [CHUNK_W-1:0] chunk_sz;
	logic [BURST_W-1:0] burst_n;
	logic [IPOOL_W-1:0] ipool_reg;

	// Shadow of the peer table and of the shared credit pool.
	logic [CNT_W-1:0] req_bytes  [DEF_NUM_PEERS];
	logic [CNT_W-1:0] cred_bytes [DEF_NUM_PEERS];
	logic [CNT_W-1:0] rcvd_bytes [DEF_NUM_PEERS];
	logic [CNT_W-1:0] pool_bytes;

	// Grants and acknowledges still owed by the block, oldest first.
	result_t grants_due [$];

	int          err_cnt = 0;
	int unsigned cycle_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          held = 1'b0;
	event        hold_ev;

	// One line of the directed script: either a register write or an input transaction,
	// with the results typed in (n >= 0) or left to the predictor (n < 0).
	typedef struct {
		bit                 is_cfg;
		logic [1:0]         idx;
		logic [APB_DW-1:0]  val;
		op_e                op;
		logic [PEER_W-1:0]  peer;
		logic [AMT_W-1:0]   amt;
		int                 n;
		result_t            e0;
		result_t            e1;
	} script_row_t;

	script_row_t script [$];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a run that stalls or loses results ends here.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == LIMIT_CYCLES) begin
			$display("tb_per_peer_credit_grant_engine_unit: errors");
			$finish;
		end
	end

	// Receiver: random stalls per phase, or a long hold-off when asked for.
	always @(posedge clk) begin
		if (held)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Count the hold-off here so the sender keeps offering while the block backs up.
	initial begin
		forever begin
			@(hold_ev);
			held = 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			held = 1'b0;
		end
	end

	// Sample at the falling edge: every signal is settled and the transaction
	// completes at the next rising edge.
	always @(negedge clk) begin : result_monitor
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{kind: m_tuser[0], peer: m_tdata[PEER_W-1:0],
				bytes: m_tdata[PEER_W+GRANT_W-1:PEER_W], last: m_tlast};
			if (grants_due.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 50)
					$display("%0t: unexpected result kind %0d peer %0d bytes %0d last %0d",
						$time, got.kind, got.peer, got.bytes, got.last);
			end else begin
				want = grants_due.pop_front();
				if (got.kind !== want.kind || got.peer !== want.peer ||
						got.bytes !== want.bytes || got.last !== want.last) begin
					err_cnt++;
					if (err_cnt <= 50)
						$display(
							"%0t: expected kind/peer/bytes/last %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
							$time, want.kind, want.peer, want.bytes, want.last,
							got.kind, got.peer, got.bytes, got.last);
				end
			end
		end
	end

	// Apply one input to the shadow table and work out the results it causes.
	function automatic int track_credit(input op_e op, input logic [PEER_W-1:0] p,
			input logic [AMT_W-1:0] a, output result_t r0, output result_t r1);
		logic [CNT_W-1:0] owed;
		logic [CNT_W-1:0] unmet;
		logic [CNT_W-1:0] cap;
		logic [CNT_W-1:0] grant;
		logic [CNT_W-1:0] sum;
		int n;
		r0 = '0;
		r1 = '0;
		grant = '0;
		n = 0;
		case (op)
			OP_REQUEST: req_bytes[p] += CNT_W'(a);
			OP_UPDATE: begin
				rcvd_bytes[p] += CNT_W'(a);
				sum = pool_bytes + CNT_W'(a);
				pool_bytes = (sum < pool_bytes) ? '1 : sum;
			end
			OP_ABORT: begin
				// Clear the entry; an abort never grants.
				req_bytes[p] = '0;
				cred_bytes[p] = '0;
				rcvd_bytes[p] = '0;
				return 0;
			end
			default: ;
		endcase
		// Grant only with a chunk in the pool and at most two chunks outstanding;
		// outstanding wraps, so a peer that sent more than it got is held off.
		if (pool_bytes >= CNT_W'(chunk_sz)) begin
			owed = cred_bytes[p] - rcvd_bytes[p];
			if (owed <= CNT_W'(chunk_sz) * 2) begin
				unmet = req_bytes[p] - cred_bytes[p];
				cap = CNT_W'(burst_n) * CNT_W'(chunk_sz);
				grant = (unmet < cap) ? unmet : cap;
				if (grant > CNT_W'(GRANT_MAX))
					grant = CNT_W'(GRANT_MAX);
				if (grant != 0) begin
					pool_bytes = (pool_bytes > grant) ? pool_bytes - grant : '0;
					cred_bytes[p] += grant;
				end
			end
		end
		// The acknowledge goes ahead of any grant on a terminate.
		if (op == OP_TERMINATE) begin
			r0 = '{kind: KIND_ACK, peer: p, bytes: '0, last: (grant == 0)};
			n = 1;
		end
		if (grant != 0) begin
			if (n == 0)
				r0 = '{kind: KIND_GRANT, peer: p, bytes: grant[GRANT_W-1:0], last: 1'b1};
			else
				r1 = '{kind: KIND_GRANT, peer: p, bytes: grant[GRANT_W-1:0], last: 1'b1};
			n++;
		end
		return n;
	endfunction

	function automatic result_t grant_of(input logic [PEER_W-1:0] p,
			input logic [GRANT_W-1:0] b);
		return '{kind: KIND_GRANT, peer: p, bytes: b, last: 1'b1};
	endfunction

	function automatic result_t ack_of(input logic [PEER_W-1:0] p, input logic l);
		return '{kind: KIND_ACK, peer: p, bytes: '0, last: l};
	endfunction

	function automatic void item_row(input op_e op, input logic [PEER_W-1:0] p,
			input logic [AMT_W-1:0] a, input int n, input result_t e0 = '0,
			input result_t e1 = '0);
		script_row_t row;
		row = '{is_cfg: 1'b0, idx: REG_CHUNK_BYTES, val: '0, op: op, peer: p, amt: a,
			n: n, e0: e0, e1: e1};
		script.push_back(row);
	endfunction

	function automatic void cfg_row(input logic [1:0] idx, input logic [APB_DW-1:0] v);
		script_row_t row;
		row = '{is_cfg: 1'b1, idx: idx, val: v, op: OP_REQUEST, peer: '0, amt: '0,
			n: 0, e0: '0, e1: '0};
		script.push_back(row);
	endfunction

	// Draw a random input. Up to 45 percent of updates return exactly the outstanding credit so that
	// peers keep cycling through grants; the rest is wide-range noise.
	function automatic void pick_item(output op_e op, output logic [PEER_W-1:0] p,
			output logic [AMT_W-1:0] a);
		logic [CNT_W-1:0] cap;
		logic [CNT_W-1:0] owed;
		int r;
		r = $urandom_range(0, 99);
		if (r < 42)
			op = OP_REQUEST;
		else if (r < 74)
			op = OP_UPDATE;
		else if (r < 92)
			op = OP_TERMINATE;
		else
			op = OP_ABORT;
		// Favor a few peers so that back-to-back hits on one entry are common.
		p = ($urandom_range(0, 99) < 65) ? PEER_W'($urandom_range(0, 3)) : PEER_W'($urandom);
		cap = CNT_W'(burst_n) * CNT_W'(chunk_sz);
		owed = cred_bytes[p] - rcvd_bytes[p];
		r = $urandom_range(0, 99);
		if (op == OP_UPDATE && r < 45 && owed < (CNT_W'(1) << AMT_W))
			a = owed[AMT_W-1:0];
		else if (r < 65)
			a = AMT_W'($urandom_range(0, 32'(cap * 2 + 1)));
		else if (r < 73)
			a = '0;
		else if (r < 80)
			a = '1;
		else if (r < 90)
			a = AMT_W'({$urandom, $urandom});
		else
			a = AMT_W'(1) << $urandom_range(0, AMT_W - 1);
	endfunction

	// Offer one input transaction, with random idle cycles ahead of it; once it is
	// taken, queue what it should produce.
	task automatic offer(input op_e op, input logic [PEER_W-1:0] p,
			input logic [AMT_W-1:0] a, input int typed_n, input result_t t0,
			input result_t t1);
		logic    rdy;
		int      n;
		result_t r0;
		result_t r1;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			// Drive junk on the data lines while valid is low.
			s_tvalid <= 1'b0;
			s_tdata <= S_TDATA_W'({$urandom, $urandom});
			s_tuser <= S_TUSER_W'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - AMT_W - PEER_W){1'b0}}, a, p};
		s_tuser <= op;
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		n = track_credit(op, p, a, r0, r1);
		if (typed_n >= 0) begin
			n = typed_n;
			r0 = t0;
			r1 = t1;
		end
		if (n > 0)
			grants_due.push_back(r0);
		if (n > 1)
			grants_due.push_back(r1);
	endtask

	// Drop valid, wait for every owed result, then let the block go quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] v);
		logic rdy;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CHUNK_BYTES:  chunk_sz = v[CHUNK_W-1:0];
			REG_BURST_CHUNKS: burst_n = v[BURST_W-1:0];
			REG_INITIAL_POOL: ipool_reg = v[IPOOL_W-1:0];
			default: ;
		endcase
	endtask

	// Read a register back and compare it with the shadow.
	task automatic reg_check(input logic [1:0] idx);
		logic              rdy;
		logic [APB_DW-1:0] got;
		logic [APB_DW-1:0] want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			rdy = pready;
			got = prdata;
			@(posedge clk);
		end while (!rdy);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CHUNK_BYTES:  want = APB_DW'(chunk_sz);
			REG_BURST_CHUNKS: want = APB_DW'(burst_n);
			default:          want = APB_DW'(ipool_reg);
		endcase
		if (got !== want) begin
			err_cnt++;
			$display("%0t: register %0d expected %0d, got %0d", $time, idx, want, got);
		end
	endtask

	// One random phase: program the registers while idle, read them back, then stream.
	task automatic run_phase(input logic [APB_DW-1:0] chunk_v, input logic [APB_DW-1:0] burst_v,
			input logic [APB_DW-1:0] pool_v, input int send_pct, input int recv_pct,
			input int count, input bit press);
		op_e               op;
		logic [PEER_W-1:0] p;
		logic [AMT_W-1:0]  a;
		settle();
		reg_write(REG_CHUNK_BYTES, chunk_v);
		reg_write(REG_BURST_CHUNKS, burst_v);
		reg_write(REG_INITIAL_POOL, pool_v);
		reg_check(REG_CHUNK_BYTES);
		reg_check(REG_BURST_CHUNKS);
		reg_check(REG_INITIAL_POOL);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		if (press)
			-> hold_ev;
		repeat (count) begin
			pick_item(op, p, a);
			offer(op, p, a, -1, '0, '0);
		end
	endtask

	initial begin
		// Hold every input at a known value from time zero.
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// Load the shadow with the reset state.
		chunk_sz = CHUNK_RESET;
		burst_n = BURST_RESET;
		ipool_reg = IPOOL_RESET;
		pool_bytes = CNT_W'(IPOOL_RESET);
		for (int i = 0; i < DEF_NUM_PEERS; i++) begin
			req_bytes[i] = '0;
			cred_bytes[i] = '0;
			rcvd_bytes[i] = '0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers must come out of reset at their documented values.
		reg_check(REG_CHUNK_BYTES);
		reg_check(REG_BURST_CHUNKS);
		reg_check(REG_INITIAL_POOL);

		// Directed script under the reset settings (chunk 30000, burst 10).
		item_row(OP_REQUEST, 4'd0, '0, 0);                          // nothing to grant
		item_row(OP_TERMINATE, 4'd0, '0, 1, ack_of(4'd0, 1'b1));
		item_row(OP_REQUEST, 4'd1, 40'd1000, 1, grant_of(4'd1, 26'd1000));
		item_row(OP_REQUEST, 4'd2, '1, 1, grant_of(4'd2, 26'd300000));   // capped at burst
		item_row(OP_REQUEST, 4'd2, '0, 0);                          // ten chunks outstanding
		item_row(OP_UPDATE, 4'd2, 40'd300000, 1, grant_of(4'd2, 26'd300000));
		item_row(OP_TERMINATE, 4'd2, '0, 1, ack_of(4'd2, 1'b1));
		// Exactly two chunks outstanding still lets a grant through.
		item_row(OP_UPDATE, 4'd2, 40'd240000, 1, grant_of(4'd2, 26'd300000));
		item_row(OP_ABORT, 4'd2, '1, 0);
		item_row(OP_TERMINATE, 4'd2, '0, 1, ack_of(4'd2, 1'b1));
		item_row(OP_REQUEST, 4'd15, 40'd50, 1, grant_of(4'd15, 26'd50));
		// Received beyond credited: outstanding wraps and blocks the peer.
		item_row(OP_UPDATE, 4'd3, 40'd5000, 0);
		item_row(OP_REQUEST, 4'd3, 40'd100, 0);
		item_row(OP_ABORT, 4'd3, '0, 0);
		item_row(OP_REQUEST, 4'd3, 40'd7, 1, grant_of(4'd3, 26'd7));
		// Zero burst: no grant, then the terminate picks up the pending credit.
		cfg_row(REG_BURST_CHUNKS, 32'd0);
		item_row(OP_REQUEST, 4'd6, 40'd1000, 0);
		cfg_row(REG_BURST_CHUNKS, 32'd10);
		item_row(OP_TERMINATE, 4'd6, '0, 2, ack_of(4'd6, 1'b0), grant_of(4'd6, 26'd1000));
		// Zero chunk size: limit is zero as well.
		cfg_row(REG_CHUNK_BYTES, 32'd0);
		item_row(OP_REQUEST, 4'd7, 40'd500, 0);
		cfg_row(REG_CHUNK_BYTES, 32'd30000);
		item_row(OP_TERMINATE, 4'd7, '0, 2, ack_of(4'd7, 1'b0), grant_of(4'd7, 26'd500));
		item_row(OP_UPDATE, 4'd8, 40'h12_3456_789A, -1);
		item_row(OP_TERMINATE, 4'd8, '0, -1);
		item_row(OP_REQUEST, 4'd9, 40'h55_5555_5555, -1);
		item_row(OP_REQUEST, 4'd9, 40'hAA_AAAA_AAAA, -1);

		send_idle_pct = 21;
		recv_stall_pct = 21;
		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				reg_write(script[i].idx, script[i].val);
			end else begin
				offer(script[i].op, script[i].peer, script[i].amt, script[i].n,
					script[i].e0, script[i].e1);
			end
		end

		// The spare index must be ignored; read everything back after hitting it.
		settle();
		reg_write(REG_SPARE, 32'hDEAD_BEEF);
		reg_check(REG_CHUNK_BYTES);
		reg_check(REG_BURST_CHUNKS);
		reg_check(REG_INITIAL_POOL);

		// Random phases: sweep settings from the smallest to beyond the grant field,
		// and every idling mix.
		run_phase(32'd30000, 32'd10, 32'd0, 0, 0, 250, 1'b0);
		run_phase(32'd1, 32'd1, 32'hFFFF_FFFF, 56, 0, 200, 1'b0);
		run_phase(32'd1048576, 32'd63, 32'd0, 0, 56, 250, 1'b0);
		// Upper bits of the write are dropped: chunk becomes 2097151, grants saturate.
		run_phase(32'hFFFF_FFFF, 32'd63, $urandom, 21, 21, 200, 1'b0);
		run_phase(32'd0, 32'hFFFF_FFC5, 32'(IPOOL_RESET), 0, 0, 100, 1'b0);
		run_phase(32'd4096, 32'd0, $urandom, 56, 0, 100, 1'b0);
		run_phase($urandom_range(1, 200000), $urandom_range(1, 63), $urandom, 0, 56, 250, 1'b0);
		// Back-pressure: receiver holds off while the sender streams without gaps.
		run_phase(32'd30000, 32'd10, $urandom, 0, 0, 150, 1'b1);
		run_phase($urandom_range(1, 200000), $urandom_range(1, 63), $urandom, 21, 21, 250,
			1'b0);

		settle();
		if (err_cnt == 0)
			$display("tb_per_peer_credit_grant_engine_unit: clean");
		else
			$display("tb_per_peer_credit_grant_engine_unit: errors");
		$finish;
	end

endmodule
